/* hdl/sqd_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// sqd_pkg
// Types and codes shared by the shortest-queue dispatcher.
// ============================================================================
package sqd_pkg;

    // Command kinds
    localparam logic KIND_ENQUEUE = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_QUEUED   = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_RELEASED = 2'd2;
    localparam logic [1:0] ST_BADIDX   = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [15:0] client_tag;
        logic [3:0]  server_sel;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  chosen_desk;
        logic [15:0] served_client;
        logic        slot_busy;
    } rsp_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_FETCH
    } fsm_state_t;

endpackage

/* hdl/shortest_queue_dispatcher_core.sv */
`timescale 1ns / 1ps
// ============================================================================
// shortest_queue_dispatcher_core
// Join-shortest-queue dispatcher: one bounded FIFO per server held in a
// shared RAM, plus per-server head pointers and fill counts in flops.
// ============================================================================
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  --------------------
//  command   in         start & !busy        cmd  (sqd_pkg::cmd_t)
//  result    out        done, one cycle      rsp  (sqd_pkg::rsp_t)
//
// An enqueue, a release of an empty queue or a bad server index gives
//   its result in the cycle after accept, and the next item may be
//   accepted right away (one item per cycle while busy stays low).
// A release that pops its queue reads the head from the queue RAM, whose
//   read data is registered; busy is high for a single cycle, in FETCH,
//   and the result is registered from FETCH; no item is accepted while busy.
// Reset clears all counts, heads and the controller; queue RAM contents
//   need no clearing since an entry is read only after it was pushed.
// The receiver cannot stall: done is a one-cycle strobe.
//
module shortest_queue_dispatcher_core #(
    parameter int NUM_SERVERS = 4,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  sqd_pkg::cmd_t cmd,
    output logic          done,
    output sqd_pkg::rsp_t rsp
);

    // Width of a server index, a fill count, a head pointer and a RAM address
    localparam int SW    = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int TW    = CW + 1;
    localparam int DEPTH = NUM_SERVERS * QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    sqd_pkg::fsm_state_t state_reg, state_next;
    logic [CW-1:0]       count_reg  [NUM_SERVERS];
    logic [CW-1:0]       count_next [NUM_SERVERS];
    logic [HW-1:0]       head_reg   [NUM_SERVERS];
    logic [HW-1:0]       head_next  [NUM_SERVERS];
    logic [3:0]          fetch_desk_reg, fetch_desk_next;
    sqd_pkg::rsp_t       rsp_reg, rsp_next;
    logic                done_reg, done_next;

    // ------------------------------------------------------------------
    // Queue RAM
    // ------------------------------------------------------------------
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    sqd_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.client_tag),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Shortest non-full queue, lowest index on a tie
    // ------------------------------------------------------------------
    logic [SW-1:0] best;
    logic [CW-1:0] best_count;
    logic          found;

    always_comb
    begin
        best       = '0;
        best_count = '1;
        found      = 1'b0;
        for (int i = 0; i < NUM_SERVERS; i++)
        begin
            if (count_reg[i] != CW'(QUEUE_DEPTH) &&
                (!found || count_reg[i] < best_count))
            begin
                best       = SW'(i);
                best_count = count_reg[i];
                found      = 1'b1;
            end
        end
    end

    // Server touched by this command: the chosen queue or the released desk
    logic          desk_ok;
    logic [SW-1:0] sel;
    logic [CW-1:0] sel_count;
    logic [HW-1:0] sel_head;
    logic [TW-1:0] tail_sum;
    logic [HW-1:0] tail;
    logic [HW-1:0] head_inc;
    logic [AW-1:0] sel_base;

    assign desk_ok   = {1'b0, cmd.server_sel} < 5'(NUM_SERVERS);
    assign sel       = (cmd.kind == sqd_pkg::KIND_ENQUEUE) ? best : cmd.server_sel[SW-1:0];
    assign sel_count = count_reg[sel];
    assign sel_head  = head_reg[sel];
    assign sel_base  = AW'(sel) * AW'(QUEUE_DEPTH);

    // head + count stays below twice the depth: one compare and subtract
    assign tail_sum  = TW'(sel_head) + TW'(sel_count);
    assign tail      = (tail_sum >= TW'(QUEUE_DEPTH)) ? HW'(tail_sum - TW'(QUEUE_DEPTH))
                                                      : HW'(tail_sum);
    assign head_inc  = (sel_head == HW'(QUEUE_DEPTH - 1)) ? '0 : HW'(sel_head + 1'b1);

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        fetch_desk_next = fetch_desk_reg;
        rsp_next        = rsp_reg;
        done_next       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = sel_base + AW'(tail);
        ram_re          = 1'b0;
        ram_raddr       = sel_base + AW'(sel_head);

        unique case (state_reg)
            sqd_pkg::FSM_IDLE:
            begin
                if (start)
                begin
                    done_next              = 1'b1;
                    rsp_next.served_client = '0;
                    rsp_next.slot_busy     = 1'b0;
                    if (cmd.kind == sqd_pkg::KIND_ENQUEUE)
                    begin
                        if (found)
                        begin
                            ram_we               = 1'b1;
                            count_next[sel]      = sel_count + 1'b1;
                            rsp_next.status      = sqd_pkg::ST_QUEUED;
                            rsp_next.chosen_desk = 4'(best);
                        end
                        else
                        begin
                            rsp_next.status      = sqd_pkg::ST_FULL;
                            rsp_next.chosen_desk = '0;
                        end
                    end
                    else if (!desk_ok)
                    begin
                        rsp_next.status      = sqd_pkg::ST_BADIDX;
                        rsp_next.chosen_desk = cmd.server_sel;
                    end
                    else
                    begin
                        rsp_next.status      = sqd_pkg::ST_RELEASED;
                        rsp_next.chosen_desk = cmd.server_sel;
                        if (sel_count != '0)
                        begin
                            // pop the head; result waits for the RAM read
                            done_next       = 1'b0;
                            ram_re          = 1'b1;
                            head_next[sel]  = head_inc;
                            count_next[sel] = sel_count - 1'b1;
                            fetch_desk_next = cmd.server_sel;
                            state_next      = sqd_pkg::FSM_FETCH;
                        end
                    end
                end
            end

            sqd_pkg::FSM_FETCH:
            begin
                done_next              = 1'b1;
                rsp_next.status        = sqd_pkg::ST_RELEASED;
                rsp_next.chosen_desk   = fetch_desk_reg;
                rsp_next.served_client = ram_rdata;
                rsp_next.slot_busy     = 1'b1;
                state_next             = sqd_pkg::FSM_IDLE;
            end

            default:
            begin
                state_next = sqd_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sqd_pkg::FSM_IDLE;
            done_reg  <= 1'b0;
            for (int i = 0; i < NUM_SERVERS; i++)
            begin
                count_reg[i] <= '0;
                head_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            count_reg <= count_next;
            head_reg  <= head_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        rsp_reg        <= rsp_next;
        fetch_desk_reg <= fetch_desk_next;
    end

    assign busy = (state_reg == sqd_pkg::FSM_FETCH);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

/* hdl/sqd_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// sqd_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ============================================================================
module sqd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                               clk,
    input  logic                               we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                   wdata,
    input  logic                               re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                   rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* test/shortest_queue_dispatcher_core_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// shortest_queue_dispatcher_core_tb
// Self-checking bench for the join-shortest-queue dispatcher. A scoreboard
// class mirrors the per-server FIFOs and service slots. Each accepted command
// is predicted into an expected result. Each done strobe is checked in order
// against the oldest expected result. Stimulus starts with directed corner
// cases and then runs random enqueue/release bursts under several
// sender-idle patterns.
// ============================================================================
module shortest_queue_dispatcher_core_tb;

    localparam int N_SERVERS   = 4;
    localparam int FIFO_DEPTH  = 8;
    localparam int STALL_LIMIT = 1000;   // cycles with no accept and no done
    localparam int MAX_REPORTS = 10;

    // ------------------------------------------------------------------------
    // Scoreboard: holds a private copy of the dispatcher state and the
    // expected results still owed by the DUT.
    // ------------------------------------------------------------------------
    class dispatch_scoreboard;
        logic [15:0]   fifo_mem [N_SERVERS][FIFO_DEPTH];
        int            fifo_head [N_SERVERS];
        int            fifo_fill [N_SERVERS];
        logic [15:0]   desk_client [N_SERVERS];
        bit            desk_busy [N_SERVERS];
        sqd_pkg::rsp_t owed_results [$];
        int            errors;

        function new();
            errors = 0;
            for (int i = 0; i < N_SERVERS; i++)
            begin
                fifo_head[i]   = 0;
                fifo_fill[i]   = 0;
                desk_client[i] = '0;
                desk_busy[i]   = 1'b0;
            end
        endfunction

        // Join shortest non-full queue, lowest index wins a tie.
        function sqd_pkg::rsp_t join_shortest(logic [15:0] id);
            sqd_pkg::rsp_t r;
            int            best;
            int            best_fill;
            int            tail;
            r         = '0;
            best      = -1;
            best_fill = FIFO_DEPTH + 1;
            for (int i = 0; i < N_SERVERS; i++)
            begin
                if (fifo_fill[i] < FIFO_DEPTH && fifo_fill[i] < best_fill)
                begin
                    best_fill = fifo_fill[i];
                    best      = i;
                end
            end
            if (best < 0)
            begin
                r.status = sqd_pkg::ST_FULL;
                return r;
            end
            tail = (fifo_head[best] + fifo_fill[best]) % FIFO_DEPTH;
            fifo_mem[best][tail] = id;
            fifo_fill[best]++;
            r.status      = sqd_pkg::ST_QUEUED;
            r.chosen_desk = best[3:0];
            return r;
        endfunction

        // Empty the desk's slot, then refill it from its queue head.
        function sqd_pkg::rsp_t release_desk(logic [3:0] desk);
            sqd_pkg::rsp_t r;
            int            d;
            r = '0;
            d = int'(desk);
            r.chosen_desk = desk;
            if (d >= N_SERVERS)
            begin
                r.status = sqd_pkg::ST_BADIDX;
                return r;
            end
            r.status       = sqd_pkg::ST_RELEASED;
            desk_busy[d]   = 1'b0;
            desk_client[d] = '0;
            if (fifo_fill[d] != 0)
            begin
                desk_client[d] = fifo_mem[d][fifo_head[d]];
                desk_busy[d]   = 1'b1;
                fifo_head[d]   = (fifo_head[d] + 1) % FIFO_DEPTH;
                fifo_fill[d]--;
                r.served_client = desk_client[d];
                r.slot_busy     = 1'b1;
            end
            return r;
        endfunction

        function void note_command(sqd_pkg::cmd_t c);
            if (c.kind == sqd_pkg::KIND_ENQUEUE)
                owed_results.push_back(join_shortest(c.client_tag));
            else
                owed_results.push_back(release_desk(c.server_sel));
        endfunction

        function void check_result(sqd_pkg::rsp_t got);
            sqd_pkg::rsp_t exp;
            if (owed_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR: unexpected result status=%0d desk=%0d client=%h busy=%0b",
                             got.status, got.chosen_desk, got.served_client, got.slot_busy);
                return;
            end
            exp = owed_results.pop_front();
            if (got.status !== exp.status || got.chosen_desk !== exp.chosen_desk ||
                got.served_client !== exp.served_client || got.slot_busy !== exp.slot_busy)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $write("ERROR: result mismatch exp status=%0d desk=%0d client=%h busy=%0b",
                           exp.status, exp.chosen_desk, exp.served_client, exp.slot_busy);
                    $display(", got status=%0d desk=%0d client=%h busy=%0b",
                             got.status, got.chosen_desk, got.served_client, got.slot_busy);
                end
            end
        endfunction

        function int owed_count();
            return owed_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    sqd_pkg::cmd_t cmd;
    logic          done;
    sqd_pkg::rsp_t rsp;

    dispatch_scoreboard sb;
    int stall_cycles;

    shortest_queue_dispatcher_core #(
        .NUM_SERVERS(N_SERVERS),
        .QUEUE_DEPTH(FIFO_DEPTH)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .cmd  (cmd),
        .done (done),
        .rsp  (rsp)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor: at each rising edge, DUT outputs still hold their pre-edge
    // values (the DUT updates through nonblocking assignments), so accept and
    // done are seen exactly as the DUT sees them. The accept is noted before
    // the check; a result always belongs to an older item, so order holds.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_command(cmd);
            if (done)
                sb.check_result(rsp);
        end
    end

    // Watchdog: counts cycles in which nothing moves in either direction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: called at a falling edge. Optionally idles start low for a
    // random number of cycles, then holds the item until it is accepted and
    // returns at the following falling edge. start gets one assignment per
    // falling edge, so back-to-back items keep it high without a glitch.
    // ------------------------------------------------------------------------
    task automatic send_item(sqd_pkg::cmd_t c, int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic send_enqueue(logic [15:0] id, int idle_pct);
        sqd_pkg::cmd_t c;
        c            = '0;
        c.kind       = sqd_pkg::KIND_ENQUEUE;
        c.client_tag = id;
        c.server_sel = 4'($urandom_range(15));
        send_item(c, idle_pct);
    endtask

    task automatic send_release(logic [3:0] desk, int idle_pct);
        sqd_pkg::cmd_t c;
        c            = '0;
        c.kind       = sqd_pkg::KIND_RELEASE;
        c.client_tag = 16'($urandom_range(65535));
        c.server_sel = desk;
        send_item(c, idle_pct);
    endtask

    // Random item: enq_pct steers fill vs drain; one release in ten is
    // aimed at a nonexistent desk.
    function automatic sqd_pkg::cmd_t random_cmd(int enq_pct);
        sqd_pkg::cmd_t c;
        c.kind       = ($urandom_range(99) < enq_pct) ? sqd_pkg::KIND_ENQUEUE
                                                      : sqd_pkg::KIND_RELEASE;
        c.client_tag = 16'($urandom_range(65535));
        if ($urandom_range(9) == 0)
            c.server_sel = 4'($urandom_range(15, N_SERVERS));
        else
            c.server_sel = 4'($urandom_range(N_SERVERS - 1));
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int idle_mix [4];
        int enq_mix [3];
        int enq_pct;

        idle_mix = '{0, 70, 11, 0};
        enq_mix  = '{85, 50, 20};

        sb    = new();
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty release, out-of-range desks, id extremes, tie break,
        // pops in order, release that empties a slot.
        send_release(4'd0, 0);
        send_release(4'd4, 0);
        send_release(4'd15, 0);
        send_enqueue(16'h0000, 0);
        send_enqueue(16'hFFFF, 0);
        send_enqueue(16'h8001, 0);
        send_enqueue(16'h7FFE, 0);
        send_enqueue(16'h1234, 0);
        send_release(4'd0, 0);
        send_release(4'd0, 0);
        send_release(4'd0, 0);
        send_release(4'd3, 0);
        // Fill every queue and push three more times: all queues full
        for (int i = 0; i < N_SERVERS * FIFO_DEPTH + 1; i++)
            send_enqueue(16'($urandom_range(65535)), 0);
        // One slot frees up in desk 1's queue, the next enqueue lands there,
        // then everything is full again.
        send_release(4'd1, 0);
        send_enqueue(16'hBEEF, 0);
        send_enqueue(16'hCAFE, 0);

        // Random: four idle patterns, each in bursts of 50 items whose
        // enqueue/release mix swings between filling and draining.
        foreach (idle_mix[p])
        begin
            for (int b = 0; b < 10; b++)
            begin
                enq_pct = enq_mix[$urandom_range(2)];
                for (int n = 0; n < 50; n++)
                    send_item(random_cmd(enq_pct), idle_mix[p]);
            end
        end
        start <= 1'b0;

        // Drain: wait for every owed result, then keep watching for strays
        while (sb.owed_count() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        if (sb.errors == 0 && sb.owed_count() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hdl/sqd_pkg.sv
hdl/sqd_ram.sv
hdl/shortest_queue_dispatcher_core.sv
test/shortest_queue_dispatcher_core_tb.sv
